[src/banknote_change_breakdown_top_macros.svh]
// Assertion macros for the banknote change breakdown block.
// Used by banknote_change_breakdown_top; expects clk_i and rst_ni in scope.
`ifndef BANKNOTE_CHANGE_BREAKDOWN_TOP_MACROS_SVH
`define BANKNOTE_CHANGE_BREAKDOWN_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BNC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("banknote change breakdown: property failed");
`define BNC_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("banknote change breakdown: forbidden condition seen");
`else
`define BNC_ASSERT(label, prop)
`define BNC_ASSERT_NEVER(label, expr)
`endif
`endif

[src/bnc_pkg.sv]
// Shared constants, types and the denomination table of the change breakdown.
// No dependencies; imported by every module of the block.
package bnc_pkg;

  localparam int unsigned DENOM_COUNT = 10;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam logic [15:0] DIVISOR0    = 16'd50000;
  localparam logic [3:0]  FIRST_IDX   = 4'd0;
  localparam logic [3:0]  LAST_IDX    = 4'd9;

  typedef logic [3:0] denom_idx_t;

  // Remainder below the largest note and its saturated count.
  typedef struct packed {
    logic [15:0] rem;
    logic [15:0] count;
  } bnc_res_t;

  function automatic logic [15:0] denom_of(input denom_idx_t idx);
    logic [15:0] d;
    unique case (idx)
      4'd0:    d = 16'd50000;
      4'd1:    d = 16'd20000;
      4'd2:    d = 16'd10000;
      4'd3:    d = 16'd5000;
      4'd4:    d = 16'd2000;
      4'd5:    d = 16'd1000;
      4'd6:    d = 16'd500;
      4'd7:    d = 16'd200;
      4'd8:    d = 16'd100;
      4'd9:    d = 16'd50;
      default: d = 16'd0;
    endcase
    return d;
  endfunction

endpackage

[src/bnc_div_cell.sv]
// One cell of the restoring divider by the largest denomination.
// Depends on bnc_pkg; a chain of these cells forms the division pipeline.
module bnc_div_cell #(
  parameter int unsigned QW = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [15:0]   rem_i,
  input  logic [QW-1:0] quo_i,
  output logic          valid_o,
  output logic [15:0]   rem_o,
  output logic [QW-1:0] quo_o
);
  import bnc_pkg::*;

  logic [16:0]   trial;
  logic          fits;
  logic [QW:0]   shifted;
  logic          valid_q;
  logic [15:0]   rem_d, rem_q;
  logic [QW-1:0] quo_d, quo_q;

  // The word holds the amount bits still to come at the top and the
  // quotient bits found so far at the bottom.
  always_comb begin
    trial   = {rem_i, quo_i[QW-1]};
    fits    = (trial >= {1'b0, DIVISOR0});
    rem_d   = fits ? 16'(trial - {1'b0, DIVISOR0}) : trial[15:0];
    shifted = {quo_i, fits};
    quo_d   = shifted[QW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;

endmodule

[src/bnc_serializer.sv]
// Output stage: emits ten results per amount, one per ready cycle.
// Depends on bnc_pkg; fed by the divider chain in the top level.
module bnc_serializer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  bnc_pkg::bnc_res_t res_i,
  output logic             ready_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [15:0]      denom_o,
  output logic [15:0]      count_o,
  output logic [5:0]       leftover_o,
  output logic             last_o
);
  import bnc_pkg::*;

  logic        valid_q;
  denom_idx_t  idx_d, idx_q;
  logic [15:0] rem_d, rem_q;
  logic [15:0] count0_q;
  logic [15:0] d;
  logic [16:0] d2;
  logic [15:0] rem_next;
  logic [15:0] q;
  logic        take;

  // Below the largest note the running remainder is under three times
  // the current denomination, so two compares settle each count.
  always_comb begin
    d  = denom_of(idx_q);
    d2 = {d, 1'b0};
    if (idx_q == FIRST_IDX) begin
      q        = count0_q;
      rem_next = rem_q;
    end else if ({1'b0, rem_q} >= d2) begin
      q        = 16'd2;
      rem_next = 16'({1'b0, rem_q} - d2);
    end else if (rem_q >= d) begin
      q        = 16'd1;
      rem_next = rem_q - d;
    end else begin
      q        = 16'd0;
      rem_next = rem_q;
    end
  end

  assign take    = valid_q && ready_i;
  assign last_o  = (idx_q == LAST_IDX);
  assign ready_o = !valid_q || (take && last_o);

  always_comb begin
    idx_d = idx_q;
    rem_d = rem_q;
    if (load_i) begin
      idx_d = FIRST_IDX;
      rem_d = res_i.rem;
    end else if (take) begin
      idx_d = idx_q + 4'd1;
      rem_d = rem_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= FIRST_IDX;
    end else begin
      if (load_i) begin
        valid_q <= 1'b1;
      end else if (take && last_o) begin
        valid_q <= 1'b0;
      end
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (load_i) begin
      count0_q <= res_i.count;
    end
  end

  assign valid_o    = valid_q;
  assign denom_o    = d;
  assign count_o    = q;
  assign leftover_o = last_o ? rem_next[5:0] : 6'd0;

endmodule

[src/banknote_change_breakdown_top.sv]
// Top level of the greedy banknote change breakdown.
// Depends on bnc_pkg, bnc_div_cell, bnc_serializer and the assertion macros.
//
// Usage:
//   The slave stream takes one amount per request in s_axis_tdata; bits at
//   and above AMOUNT_BITS are ignored. For every amount the master stream
//   gives ten requests, largest note first (50000 down to 50), each with
//   the note value and the count taken. The tenth carries tlast and the
//   leftover below 50; the leftover field is zero on the other nine.
//   A chain of AMOUNT_BITS - 15 divider cells finds the count of the
//   largest note one quotient bit per cell; the output stage then works
//   out the nine smaller counts one per cycle as the receiver takes them.
//   The amount passes through the divider cells and is registered in the
//   output stage before its first result is valid. The single result
//   channel sets the rate of amounts; the divider chain keeps taking
//   amounts while results drain. When the receiver stalls, the output
//   stage holds its request and the divider chain stops once a finished
//   amount waits at its end, which then drops s_axis_tready. Reset empties
//   the chain and the output stage.
`include "banknote_change_breakdown_top_macros.svh"
module banknote_change_breakdown_top #(
  parameter int unsigned AMOUNT_BITS = 31,
  localparam int unsigned IN_TDATA_W = ((AMOUNT_BITS + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [AMOUNT_BITS-1:0] amount, zero padding above
  input  logic [IN_TDATA_W-1:0]              s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [15:0] denomination, [31:16] unit_count, [37:32] leftover, [39:38] zero
  output logic [bnc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast
);
  import bnc_pkg::*;

  localparam int unsigned QW = AMOUNT_BITS - 15;

  logic [AMOUNT_BITS-1:0]     amount;
  logic [QW:0]                vld;
  logic [QW:0][15:0]          rem;
  logic [QW:0][QW-1:0]        quo;
  logic                       en;
  logic                       ser_ready;
  logic                       ser_load;
  logic [31:0]                q_wide;
  bnc_res_t                   res;
  logic [15:0]                denom;
  logic [15:0]                count;
  logic [5:0]                 leftover;

  assign amount = s_axis_tdata[AMOUNT_BITS-1:0];

  // The top fifteen amount bits are already below the largest note.
  assign vld[0] = s_axis_tvalid;
  assign rem[0] = {1'b0, amount[AMOUNT_BITS-1:QW]};
  assign quo[0] = amount[QW-1:0];

  assign en            = !vld[QW] || ser_ready;
  assign s_axis_tready = en;
  assign ser_load      = vld[QW] && ser_ready;

  for (genvar i = 0; i < QW; i++) begin : g_div
    bnc_div_cell #(
      .QW(QW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld[i]),
      .rem_i   (rem[i]),
      .quo_i   (quo[i]),
      .valid_o (vld[i+1]),
      .rem_o   (rem[i+1]),
      .quo_o   (quo[i+1])
    );
  end

  // Wide amounts can give a count beyond sixteen bits; it saturates.
  assign q_wide    = 32'(quo[QW]);
  assign res.rem   = rem[QW];
  assign res.count = (q_wide > 32'd65535) ? 16'hFFFF : q_wide[15:0];

  bnc_serializer u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (ser_load),
    .res_i      (res),
    .ready_o    (ser_ready),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .denom_o    (denom),
    .count_o    (count),
    .leftover_o (leftover),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, leftover, count, denom};

  `BNC_ASSERT(a_last_is_fifty, m_axis_tvalid && m_axis_tlast |-> denom == 16'd50)
  `BNC_ASSERT_NEVER(a_leftover_early, m_axis_tvalid && !m_axis_tlast && leftover != 6'd0)
  `BNC_ASSERT_NEVER(a_small_count, m_axis_tvalid && denom != 16'd50000 && count > 16'd2)
  `BNC_ASSERT(a_load_shows, ser_load |=> m_axis_tvalid && denom == 16'd50000)

endmodule
